[hdl/grsc_pkg.sv]
// Shared types, constants and helper functions for the gyro rate stability classifier.
package grsc_pkg;

   localparam int RING_DEPTH = 8;
   localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

   localparam int CSR_IW = 3;
   localparam int CSR_DW = 16;

   localparam logic [CSR_IW-1:0] REG_RATE_OFFSET    = 3'd0;
   localparam logic [CSR_IW-1:0] REG_STABLE_LIMIT   = 3'd1;
   localparam logic [CSR_IW-1:0] REG_UNSTABLE_LIMIT = 3'd2;
   localparam logic [CSR_IW-1:0] REG_FALLING_LIMIT  = 3'd3;
   localparam logic [CSR_IW-1:0] REG_GAIN_CURRENT   = 3'd4;
   localparam logic [CSR_IW-1:0] REG_GAIN_PREVIOUS  = 3'd5;

   localparam logic KIND_SAMPLE   = 1'b0;
   localparam logic KIND_EVALUATE = 1'b1;

   typedef enum logic [1:0] {
      STAB_UNDECIDED = 2'd0,
      STAB_UNSTABLE  = 2'd1,
      STAB_STABLE    = 2'd2,
      STAB_FALLING   = 2'd3
   } stab_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL_CUR,
      ST_MUL_PREV,
      ST_SUM,
      ST_SCALE,
      ST_CLASSIFY,
      ST_DONE
   } state_type;

   // clamp an 18-bit signed value into signed 16 bits
   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // true when v lies outside plus or minus lim
   function automatic logic beyond(input logic signed [15:0] v, input logic [14:0] lim);
      logic signed [16:0] vx;
      logic signed [16:0] lx;
      vx = {v[15], v};
      lx = {2'b00, lim};
      return (vx > lx) || (vx < -lx);
   endfunction

endpackage

[hdl/grsc_req_if.sv]
// Request channel interface: item kind and raw rate.
interface grsc_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [15:0] raw_rate;

   modport source (output valid, output kind, output raw_rate, input ready);
   modport sink   (input valid, input kind, input raw_rate, output ready);
endinterface

[hdl/grsc_rsp_if.sv]
// Response channel interface: corrected rate, filtered rate and stability class.
interface grsc_rsp_if import grsc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic signed [15:0] corrected_rate;
   logic signed [15:0] filtered_rate;
   stab_type           stability;

   modport source (output valid, output corrected_rate, output filtered_rate,
                   output stability, input ready);
   modport sink   (input valid, input corrected_rate, input filtered_rate,
                   input stability, output ready);
endinterface

[hdl/grsc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module grsc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

[hdl/gyro_rate_stability_classifier_core.sv]
// Top level of the gyro rate stability classifier.
//
//   channel   dir  transfer content                               handshake
//   req_chan  in   kind, raw_rate                                 valid/ready
//   rsp_chan  out  corrected_rate, filtered_rate, stability       valid/ready
//   csr_*     in   csr_index, csr_data (six registers)            csr_we, no wait
//
// Sample: its response is loaded at the edge of the request transfer.
// Evaluate: ring walk on the RAM read port, then the filter steps unless stable
// (shared 16x16 multiplier twice, sum, scale, classify). Synchronous reset; valid
// bits clear the ring at once and req ready stays low in reset. A request is taken
// while a response waits only if it transfers that cycle; a stall holds the final state.
module gyro_rate_stability_classifier_core
   import grsc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   grsc_req_if.sink          req_chan,
   grsc_rsp_if.source        rsp_chan,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_data
);

   // configuration
   logic signed [15:0] rate_offset_ff,    rate_offset_in;
   logic [14:0]        stable_limit_ff,   stable_limit_in;
   logic [14:0]        unstable_limit_ff, unstable_limit_in;
   logic [14:0]        falling_limit_ff,  falling_limit_in;
   logic signed [15:0] gain_cur_ff,       gain_cur_in;
   logic signed [15:0] gain_prev_ff,      gain_prev_in;

   // architectural state outside the ring
   logic [RING_AW-1:0] write_slot_ff, write_slot_in;
   logic [RING_DEPTH-1:0] ring_vld_ff, ring_vld_in;
   logic signed [15:0] latest_ff, latest_in;
   logic signed [15:0] filt_ff,   filt_in;
   stab_type           stab_ff,   stab_in;

   // sequencer
   state_type          state_ff, state_in;
   logic [RING_AW:0]   issue_cnt_ff, issue_cnt_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [RING_AW-1:0] chk_idx_ff, chk_idx_in;
   logic               stable_ff, stable_in;

   // filter datapath
   logic signed [31:0] prod_cur_ff,  prod_cur_in;
   logic signed [31:0] prod_prev_ff, prod_prev_in;
   logic signed [32:0] sum_ff,       sum_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_corr_ff,  rsp_corr_in;
   logic signed [15:0] rsp_filt_ff,  rsp_filt_in;
   stab_type           rsp_stab_ff,  rsp_stab_in;

   // combinational
   logic               req_fire;
   logic               rsp_free;
   logic               issuing;
   logic               last_chk;
   logic               entry_bad;
   logic               scan_ok;
   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [RING_AW-1:0] ram_rd_addr;
   logic [15:0]        ram_rd_data;
   logic signed [15:0] entry;
   logic signed [16:0] diff;
   logic signed [15:0] corrected;
   logic signed [15:0] mul_a, mul_b;
   logic signed [31:0] product;
   logic signed [32:0] rounded;

   grsc_ram #(
      .WIDTH(16),
      .DEPTH(RING_DEPTH)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(write_slot_ff),
      .wr_data(corrected),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // output free now or freed by this cycle's transfer
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire = req_chan.valid && req_chan.ready;

   assign diff      = {req_chan.raw_rate[15], req_chan.raw_rate}
                    - {rate_offset_ff[15], rate_offset_ff};
   assign corrected = sat16({diff[16], diff});

   // never-written entries read as zero
   assign entry     = ring_vld_ff[chk_idx_ff] ? $signed(ram_rd_data) : 16'sd0;
   assign entry_bad = beyond(entry, stable_limit_ff);
   assign last_chk  = chk_vld_ff && (chk_idx_ff == RING_AW'(RING_DEPTH - 1));
   assign scan_ok   = stable_ff && !entry_bad;
   assign issuing   = issue_cnt_ff < (RING_AW + 1)'(RING_DEPTH);

   // one multiplier, shared by both filter terms
   assign mul_a   = (state_ff == ST_MUL_CUR) ? latest_ff : filt_ff;
   assign mul_b   = (state_ff == ST_MUL_CUR) ? gain_cur_ff : gain_prev_ff;
   assign product = mul_a * mul_b;

   // divide by 2^15 truncating toward zero: bias negative sums before the shift
   assign rounded = sum_ff + (sum_ff[32] ? 33'sd32767 : 33'sd0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_chan.kind == KIND_EVALUATE) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_chk) begin
               state_in = scan_ok ? ST_DONE : ST_MUL_CUR;
            end
         end
         ST_MUL_CUR:  state_in = ST_MUL_PREV;
         ST_MUL_PREV: state_in = ST_SUM;
         ST_SUM:      state_in = ST_SCALE;
         ST_SCALE:    state_in = ST_CLASSIFY;
         ST_CLASSIFY: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_chan.ready = 1'b0;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = issue_cnt_ff[RING_AW-1:0];
      ram_wr_en      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = rsp_free && !reset;
            ram_wr_en      = req_fire && (req_chan.kind == KIND_SAMPLE);
         end
         ST_SCAN: begin
            ram_rd_en = issuing;
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      rate_offset_in    = rate_offset_ff;
      stable_limit_in   = stable_limit_ff;
      unstable_limit_in = unstable_limit_ff;
      falling_limit_in  = falling_limit_ff;
      gain_cur_in       = gain_cur_ff;
      gain_prev_in      = gain_prev_ff;
      write_slot_in     = write_slot_ff;
      ring_vld_in       = ring_vld_ff;
      latest_in         = latest_ff;
      filt_in           = filt_ff;
      stab_in           = stab_ff;
      issue_cnt_in      = issue_cnt_ff;
      chk_vld_in        = 1'b0;
      chk_idx_in        = chk_idx_ff;
      stable_in         = stable_ff;
      prod_cur_in       = prod_cur_ff;
      prod_prev_in      = prod_prev_ff;
      sum_in            = sum_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_chan.ready;
      rsp_corr_in       = rsp_corr_ff;
      rsp_filt_in       = rsp_filt_ff;
      rsp_stab_in       = rsp_stab_ff;

      if (csr_we) begin
         unique case (csr_index)
            REG_RATE_OFFSET:    rate_offset_in    = $signed(csr_data);
            REG_STABLE_LIMIT:   stable_limit_in   = csr_data[14:0];
            REG_UNSTABLE_LIMIT: unstable_limit_in = csr_data[14:0];
            REG_FALLING_LIMIT:  falling_limit_in  = csr_data[14:0];
            REG_GAIN_CURRENT:   gain_cur_in       = $signed(csr_data);
            REG_GAIN_PREVIOUS:  gain_prev_in      = $signed(csr_data);
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.kind == KIND_SAMPLE) begin
                  latest_in                  = corrected;
                  ring_vld_in[write_slot_ff] = 1'b1;
                  write_slot_in = (write_slot_ff == RING_AW'(RING_DEPTH - 1)) ?
                                  '0 : write_slot_ff + 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_corr_in   = corrected;
                  rsp_filt_in   = filt_ff;
                  rsp_stab_in   = stab_ff;
               end else begin
                  issue_cnt_in = '0;
                  stable_in    = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (issuing) begin
               issue_cnt_in = issue_cnt_ff + 1'b1;
               chk_vld_in   = 1'b1;
               chk_idx_in   = issue_cnt_ff[RING_AW-1:0];
            end
            if (chk_vld_ff && entry_bad) begin
               stable_in = 1'b0;
            end
            if (last_chk && scan_ok) begin
               stab_in = STAB_STABLE;
            end
         end
         ST_MUL_CUR:  prod_cur_in  = product;
         ST_MUL_PREV: prod_prev_in = product;
         ST_SUM:      sum_in = {prod_cur_ff[31], prod_cur_ff} + {prod_prev_ff[31], prod_prev_ff};
         ST_SCALE:    filt_in = sat16(rounded[32:15]);
         ST_CLASSIFY: begin
            // falling wins over unstable whatever the limit order
            priority if (beyond(filt_ff, falling_limit_ff)) begin
               stab_in = STAB_FALLING;
            end else if (beyond(filt_ff, unstable_limit_ff)) begin
               stab_in = STAB_UNSTABLE;
            end else begin
               stab_in = STAB_UNDECIDED;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_corr_in  = latest_ff;
               rsp_filt_in  = filt_ff;
               rsp_stab_in  = stab_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_offset_ff    <= 16'sd0;
         stable_limit_ff   <= 15'd10;
         unstable_limit_ff <= 15'd100;
         falling_limit_ff  <= 15'd400;
         gain_cur_ff       <= 16'sd16384;
         gain_prev_ff      <= 16'sd16384;
         write_slot_ff     <= '0;
         ring_vld_ff       <= '0;
         latest_ff         <= 16'sd0;
         filt_ff           <= 16'sd0;
         stab_ff           <= STAB_UNDECIDED;
         state_ff          <= ST_IDLE;
         chk_vld_ff        <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rate_offset_ff    <= rate_offset_in;
         stable_limit_ff   <= stable_limit_in;
         unstable_limit_ff <= unstable_limit_in;
         falling_limit_ff  <= falling_limit_in;
         gain_cur_ff       <= gain_cur_in;
         gain_prev_ff      <= gain_prev_in;
         write_slot_ff     <= write_slot_in;
         ring_vld_ff       <= ring_vld_in;
         latest_ff         <= latest_in;
         filt_ff           <= filt_in;
         stab_ff           <= stab_in;
         state_ff          <= state_in;
         chk_vld_ff        <= chk_vld_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      issue_cnt_ff <= issue_cnt_in;
      chk_idx_ff   <= chk_idx_in;
      stable_ff    <= stable_in;
      prod_cur_ff  <= prod_cur_in;
      prod_prev_ff <= prod_prev_in;
      sum_ff       <= sum_in;
      rsp_corr_ff  <= rsp_corr_in;
      rsp_filt_ff  <= rsp_filt_in;
      rsp_stab_ff  <= rsp_stab_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.corrected_rate = rsp_corr_ff;
   assign rsp_chan.filtered_rate  = rsp_filt_ff;
   assign rsp_chan.stability      = rsp_stab_ff;

endmodule

[hdl/grsc_checker.sv]
// Port-level assertions for the classifier core and the bind that attaches them.
module grsc_checker
   import grsc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_kind,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [33:0] rsp_payload
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a sample answers in the next cycle
   a_sample_turn: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_SAMPLE |=> rsp_valid)
      else $error("sample transfer gave no response next cycle");

   // an evaluate walks the ring first
   a_eval_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_EVALUATE |=> !rsp_valid)
      else $error("evaluate answered too early");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response blocked");

endmodule

bind gyro_rate_stability_classifier_core grsc_checker u_grsc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_kind   (req_chan.kind),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_payload({rsp_chan.corrected_rate, rsp_chan.filtered_rate, rsp_chan.stability})
);
